// File: hdl/assert_macros.svh
// Assertion macros shared by the summed-area table block.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked on every rising edge of clk_i while rst_ni is high.
`define TDPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checked on every rising edge of clk_i, reset included.
`define TDPS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define TDPS_ASSERT(lbl, prop, msg)
`define TDPS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: hdl/tdps_pkg.sv
// Shared types and constants of the summed-area table block.
// No dependencies; imported by the interfaces and by every module.
package tdps_pkg;

  // Fixed field widths of the channels.
  localparam int unsigned SUM_W   = 28;
  localparam int unsigned ELEM_W  = 12;
  localparam int unsigned COORD_W = 9;

  // Depth of the command queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Grid size after reset.
  localparam logic [COORD_W-1:0] GRID_RESET = 9'd256;

  // Transaction kinds on the request channel.
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Command handed from front to back. Indexes are zero-based.
  // A load writes (row_b, col_b) and reads the entry above at (row_a, col_b).
  // A query reads the four corners built from row_a/row_b and col_a/col_b.
  typedef struct packed {
    logic               is_query;
    logic               bad;
    logic               zero_row_a;
    logic               zero_col_a;
    logic [COORD_W-1:0] row_a;
    logic [COORD_W-1:0] row_b;
    logic [COORD_W-1:0] col_a;
    logic [COORD_W-1:0] col_b;
    logic [SUM_W-1:0]   row_sum;
  } cmd_t;

endpackage

// File: hdl/tdps_req_if.sv
// Request channel of the summed-area table block: loads and queries.
// Depends on tdps_pkg for the field widths.
interface tdps_req_if import tdps_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               mode;
  logic [ELEM_W-1:0]  element;
  logic [COORD_W-1:0] top_row;
  logic [COORD_W-1:0] left_col;
  logic [COORD_W-1:0] bottom_row;
  logic [COORD_W-1:0] right_col;

  modport source (output valid, mode, element, top_row, left_col, bottom_row, right_col,
                  input ready);
  modport sink (input valid, mode, element, top_row, left_col, bottom_row, right_col,
                output ready);
endinterface

// File: hdl/tdps_rsp_if.sv
// Response channel of the summed-area table block: one transaction per query.
// Depends on tdps_pkg for the field widths.
interface tdps_rsp_if import tdps_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SUM_W-1:0] rect_sum;
  logic             bad_query;

  modport source (output valid, rect_sum, bad_query, input ready);
  modport sink (input valid, rect_sum, bad_query, output ready);
endinterface

// File: hdl/tdps_cfg_if.sv
// Configuration write channel of the summed-area table block (grid size).
// Depends on tdps_pkg for the field width.
interface tdps_cfg_if import tdps_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] grid_size;

  modport source (output valid, grid_size, input ready);
  modport sink (input valid, grid_size, output ready);
endinterface

// File: hdl/tdps_front.sv
// Front end: accepts requests, keeps the raster load position and row sum,
// validates query corners and turns every transaction into a command.
// Depends on tdps_pkg, tdps_req_if and tdps_cfg_if.
module tdps_front import tdps_pkg::*; #(
  parameter int unsigned MAX_SIZE  = 256,
  parameter int unsigned ELEM_BITS = 12
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tdps_req_if.sink   req_i,
  tdps_cfg_if.sink   cfg_i,
  input  logic       full_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  // Row sum width: enough for a full row of maximum elements, wrapping as the table does.
  localparam int unsigned RS_RAW = ELEM_BITS + $clog2(MAX_SIZE + 1);
  localparam int unsigned RS_W   = (RS_RAW > SUM_W) ? SUM_W : RS_RAW;
  localparam int unsigned EB     = (ELEM_BITS > ELEM_W) ? ELEM_W : ELEM_BITS;
  localparam logic [ELEM_W-1:0] ELEM_MASK = ELEM_W'((32'd1 << EB) - 32'd1);

  logic [COORD_W-1:0] grid_q;
  logic [COORD_W-1:0] row_q, row_d;
  logic [COORD_W-1:0] col_q, col_d;
  logic [RS_W-1:0]    rsum_q, rsum_d;
  logic               full_q, full_d;

  logic [COORD_W-1:0] n;
  logic               restart;
  logic [COORD_W-1:0] cur_row, cur_col;
  logic [RS_W-1:0]    rs_base, rs_new;
  logic [ELEM_W-1:0]  elem_use;
  logic               last_col, last_row;
  logic               bad;

  // Grid size in use, clamped to the legal range.
  always_comb begin
    if (grid_q == '0) begin
      n = COORD_W'(1);
    end else if (32'(grid_q) > MAX_SIZE) begin
      n = COORD_W'(MAX_SIZE);
    end else begin
      n = grid_q;
    end
  end

  // Handshake: the queue decides whether a request can be taken.
  assign req_i.ready = !full_i;
  assign cfg_i.ready = 1'b1;
  assign push_o      = req_i.valid && req_i.ready;

  // Load bookkeeping and query checks.
  always_comb begin
    restart  = full_q || (row_q > n) || (col_q > n);
    cur_row  = restart ? COORD_W'(1) : row_q;
    cur_col  = restart ? COORD_W'(1) : col_q;
    rs_base  = restart ? '0 : rsum_q;
    elem_use = req_i.element & ELEM_MASK;
    rs_new   = rs_base + RS_W'(elem_use);
    last_col = (cur_col >= n);
    last_row = (cur_row >= n);

    bad = !full_q || (req_i.top_row == '0) || (req_i.left_col == '0) ||
          (req_i.bottom_row > n) || (req_i.right_col > n) ||
          (req_i.top_row > req_i.bottom_row) || (req_i.left_col > req_i.right_col);

    cmd_o = '0;
    if (req_i.mode == MODE_QUERY) begin
      cmd_o.is_query   = 1'b1;
      cmd_o.bad        = bad;
      cmd_o.row_b      = req_i.bottom_row - COORD_W'(1);
      cmd_o.col_b      = req_i.right_col - COORD_W'(1);
      cmd_o.row_a      = req_i.top_row - COORD_W'(2);
      cmd_o.col_a      = req_i.left_col - COORD_W'(2);
      cmd_o.zero_row_a = (req_i.top_row == COORD_W'(1));
      cmd_o.zero_col_a = (req_i.left_col == COORD_W'(1));
    end else begin
      cmd_o.row_b      = cur_row - COORD_W'(1);
      cmd_o.col_b      = cur_col - COORD_W'(1);
      cmd_o.row_a      = cur_row - COORD_W'(2);
      cmd_o.zero_row_a = (cur_row == COORD_W'(1));
      cmd_o.row_sum    = SUM_W'(rs_new);
    end

    // Next raster position after this load.
    if (last_col) begin
      col_d  = COORD_W'(1);
      rsum_d = '0;
      row_d  = last_row ? COORD_W'(1) : cur_row + COORD_W'(1);
    end else begin
      col_d  = cur_col + COORD_W'(1);
      rsum_d = rs_new;
      row_d  = cur_row;
    end
    full_d = last_col && last_row;
  end

  // Load position registers; a grid size write restarts loading.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_q <= GRID_RESET;
      row_q  <= COORD_W'(1);
      col_q  <= COORD_W'(1);
      rsum_q <= '0;
      full_q <= 1'b0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      grid_q <= cfg_i.grid_size;
      row_q  <= COORD_W'(1);
      col_q  <= COORD_W'(1);
      rsum_q <= '0;
      full_q <= 1'b0;
    end else if (push_o && (req_i.mode == MODE_LOAD)) begin
      row_q  <= row_d;
      col_q  <= col_d;
      rsum_q <= rsum_d;
      full_q <= full_d;
    end
  end

endmodule

// File: hdl/tdps_fifo.sv
// Short command queue between front and back of the summed-area table block.
// Depends on tdps_pkg for cmd_t and the queue depth.
`include "assert_macros.svh"
module tdps_fifo import tdps_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  input  logic pop_i,
  output cmd_t data_o,
  output logic full_o,
  output logic empty_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entries_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  assign full_o  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = entries_q[rd_ptr_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  `TDPS_ASSERT(a_no_push_when_full, !(push_i && full_o), "push into a full command queue")
  `TDPS_ASSERT(a_no_pop_when_empty, !(pop_i && empty_o), "pop from an empty command queue")
  `TDPS_ASSERT_ALWAYS(a_count_bound, count_q <= CNT_W'(QUEUE_DEPTH), "queue count overflow")

endmodule

// File: hdl/tdps_back.sv
// Back end: owns the single-port prefix table, performs load writes and the
// four corner reads of a query, and holds the response register.
// Depends on tdps_pkg and tdps_rsp_if.
`include "assert_macros.svh"
module tdps_back import tdps_pkg::*; #(
  parameter int unsigned MAX_SIZE = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cmd_valid_i,
  input  cmd_t       cmd_i,
  output logic       pop_o,
  tdps_rsp_if.source rsp_o
);

  localparam int unsigned DEPTH = MAX_SIZE * MAX_SIZE;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD_WR,
    ST_QUERY_RD,
    ST_QUERY_END,
    ST_HOLD
  } state_e;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               neg;
    logic               zero;
  } corner_t;

  // Corner k of a query: bottom-right, top-right, bottom-left, top-left.
  function automatic corner_t pick_corner(input cmd_t c, input logic [1:0] k);
    corner_t p;
    unique case (k)
      2'd0: p = '{row: c.row_b, col: c.col_b, neg: 1'b0, zero: 1'b0};
      2'd1: p = '{row: c.row_a, col: c.col_b, neg: 1'b1, zero: c.zero_row_a};
      2'd2: p = '{row: c.row_b, col: c.col_a, neg: 1'b1, zero: c.zero_col_a};
      2'd3: p = '{row: c.row_a, col: c.col_a, neg: 1'b0,
                  zero: c.zero_row_a || c.zero_col_a};
      default: p = '0;
    endcase
    return p;
  endfunction

  function automatic logic [AW-1:0] tab_addr(input logic [COORD_W-1:0] row,
                                             input logic [COORD_W-1:0] col);
    return AW'(row) * AW'(MAX_SIZE) + AW'(col);
  endfunction

  logic [SUM_W-1:0] mem [DEPTH];
  logic [SUM_W-1:0] rd_data_q;

  state_e           state_q;
  cmd_t             cmd_q;
  logic [1:0]       step_q;
  logic             pend_neg_q, pend_zero_q;
  logic [SUM_W-1:0] acc_q;
  logic             bad_q;
  logic             out_valid_q;
  logic [SUM_W-1:0] out_sum_q;
  logic             out_bad_q;

  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_addr;
  logic [SUM_W-1:0] mem_wdata;
  corner_t          cur_corner;
  logic [SUM_W-1:0] term, acc_add;
  logic             out_free;

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.rect_sum  = out_sum_q;
  assign rsp_o.bad_query = out_bad_q;

  assign pop_o      = (state_q == ST_IDLE) && cmd_valid_i;
  assign out_free   = !out_valid_q || rsp_o.ready;
  assign cur_corner = pick_corner(cmd_q, step_q);
  assign term       = pend_zero_q ? '0 : rd_data_q;
  assign acc_add    = pend_neg_q ? acc_q - term : acc_q + term;

  // Table port control: one read or one write per cycle.
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = tab_addr(cmd_i.row_b, cmd_i.col_b);
    mem_wdata = cmd_i.row_sum;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && !cmd_i.is_query) begin
          if (cmd_i.zero_row_a) begin
            mem_we = 1'b1;
          end else begin
            mem_re   = 1'b1;
            mem_addr = tab_addr(cmd_i.row_a, cmd_i.col_b);
          end
        end else if (cmd_valid_i && !cmd_i.bad) begin
          mem_re = 1'b1;
        end
      end
      ST_LOAD_WR: begin
        mem_we    = 1'b1;
        mem_addr  = tab_addr(cmd_q.row_b, cmd_q.col_b);
        mem_wdata = cmd_q.row_sum + rd_data_q;
      end
      ST_QUERY_RD: begin
        mem_re   = !cur_corner.zero;
        mem_addr = tab_addr(cur_corner.row, cur_corner.col);
      end
      default: begin
      end
    endcase
  end

  // Prefix table, single port with registered read data.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end else if (mem_re) begin
      rd_data_q <= mem[mem_addr];
    end
  end

  // Sequencer and response register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cmd_q       <= '0;
      step_q      <= '0;
      pend_neg_q  <= 1'b0;
      pend_zero_q <= 1'b0;
      acc_q       <= '0;
      bad_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_sum_q   <= '0;
      out_bad_q   <= 1'b0;
    end else begin
      if (out_valid_q && rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i) begin
            cmd_q <= cmd_i;
            if (!cmd_i.is_query) begin
              if (!cmd_i.zero_row_a) begin
                state_q <= ST_LOAD_WR;
              end
            end else if (cmd_i.bad) begin
              if (out_free) begin
                out_valid_q <= 1'b1;
                out_sum_q   <= '0;
                out_bad_q   <= 1'b1;
              end else begin
                acc_q   <= '0;
                bad_q   <= 1'b1;
                state_q <= ST_HOLD;
              end
            end else begin
              // First corner read is issued now.
              acc_q       <= '0;
              pend_neg_q  <= 1'b0;
              pend_zero_q <= 1'b0;
              step_q      <= 2'd1;
              state_q     <= ST_QUERY_RD;
            end
          end
        end
        ST_LOAD_WR: begin
          state_q <= ST_IDLE;
        end
        ST_QUERY_RD: begin
          acc_q       <= acc_add;
          pend_neg_q  <= cur_corner.neg;
          pend_zero_q <= cur_corner.zero;
          step_q      <= step_q + 2'd1;
          if (step_q == 2'd3) begin
            state_q <= ST_QUERY_END;
          end
        end
        ST_QUERY_END: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_sum_q   <= acc_add;
            out_bad_q   <= 1'b0;
            state_q     <= ST_IDLE;
          end else begin
            acc_q   <= acc_add;
            bad_q   <= 1'b0;
            state_q <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_sum_q   <= acc_q;
            out_bad_q   <= bad_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  `TDPS_ASSERT(a_port_exclusive, !(mem_we && mem_re), "table read and write in one cycle")
  `TDPS_ASSERT(a_load_wr_after_rd, (state_q == ST_LOAD_WR) |-> $past(mem_re), "load write without read of the entry above")
  `TDPS_ASSERT(a_query_end_emits, (state_q == ST_QUERY_END && out_free) |=> out_valid_q, "finished query not presented")

endmodule

// File: hdl/two_d_prefix_sum_query.sv
// Top level of the summed-area table block: front end, command queue, back end.
// Depends on tdps_pkg, the channel interfaces, tdps_front, tdps_fifo and tdps_back.
//
//   Channel  Direction  Carries
//   req_i    in         mode, element, top_row, left_col, bottom_row, right_col
//   rsp_o    out        rect_sum, bad_query (one transaction per query)
//   cfg_i    in         grid_size
//
// A load in the first row is one write; any other load reads the entry above, then writes.
// A valid query reads four corners over the single table port; a rejected one reads none.
// Reset clears the load position and table-full flag; the table itself is not cleared.
// A two-entry command queue and the response register let either side stall alone.
module two_d_prefix_sum_query import tdps_pkg::*; #(
  parameter int unsigned MAX_SIZE  = 256,
  parameter int unsigned ELEM_BITS = 12
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tdps_req_if.sink   req_i,
  tdps_cfg_if.sink   cfg_i,
  tdps_rsp_if.source rsp_o
);

  logic push, pop, full, empty;
  cmd_t cmd_in, cmd_out;

  // Request classification and load bookkeeping.
  tdps_front #(
    .MAX_SIZE  (MAX_SIZE),
    .ELEM_BITS (ELEM_BITS)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cfg_i  (cfg_i),
    .full_i (full),
    .push_o (push),
    .cmd_o  (cmd_in)
  );

  // Command queue.
  tdps_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .pop_i   (pop),
    .data_o  (cmd_out),
    .full_o  (full),
    .empty_o (empty)
  );

  // Table access and response.
  tdps_back #(
    .MAX_SIZE (MAX_SIZE)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!empty),
    .cmd_i       (cmd_out),
    .pop_o       (pop),
    .rsp_o       (rsp_o)
  );

endmodule
